// ===== hw/rtl/rbm_pkg.sv =====
// Shared constants, types and state codes for the road rebuild MST block.
package rbm_pkg;

  localparam int MAX_NODES = 64;
  localparam int NODE_W    = $clog2(MAX_NODES);
  localparam int MAX_EDGES = 2016;
  localparam int EDGE_AW   = $clog2(MAX_EDGES + 1);
  localparam int COST_W    = 6;
  localparam int WBIAS     = (1 << COST_W) - 1;
  localparam int NUM_W     = 2 * WBIAS + 1;
  localparam int WIDX_W    = $clog2(NUM_W);
  localparam int CNT_W     = 7;
  localparam int TOT_W     = 17;

  // weight stored with a bias so that buckets are plain unsigned indexes
  typedef struct packed {
    logic [NODE_W-1:0] a;
    logic [NODE_W-1:0] b;
    logic [WIDX_W-1:0] wb;
  } edge_t;

  typedef enum logic [9:0] {
    S_LOAD   = 10'b0000000001,
    S_INIT   = 10'b0000000010,
    S_WSEL   = 10'b0000000100,
    S_ERD    = 10'b0000001000,
    S_ECHK   = 10'b0000010000,
    S_FA_RD  = 10'b0000100000,
    S_FA_CHK = 10'b0001000000,
    S_FB_RD  = 10'b0010000000,
    S_FB_CHK = 10'b0100000000,
    S_DONE   = 10'b1000000000
  } state_t;

endpackage

// ===== hw/rtl/rbm_edge_mem.sv =====
// Edge store: single write port, single registered read port.
module rbm_edge_mem
  import rbm_pkg::*;
(
  input  logic               clk,
  input  logic               we,
  input  logic [EDGE_AW-1:0] waddr,
  input  edge_t              wdata,
  input  logic [EDGE_AW-1:0] raddr,
  output edge_t              rdata
);

  edge_t mem [MAX_EDGES];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hw/rtl/rbm_parent_mem.sv =====
// Union-find parent table: one write port, one registered read port.
module rbm_parent_mem
  import rbm_pkg::*;
(
  input  logic              clk,
  input  logic              we,
  input  logic [NODE_W-1:0] waddr,
  input  logic [NODE_W-1:0] wdata,
  input  logic [NODE_W-1:0] raddr,
  output logic [NODE_W-1:0] rdata
);

  logic [NODE_W-1:0] mem [MAX_NODES];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hw/rtl/road_rebuild_mst_cost.sv =====
// Road rebuild MST cost: pair loader, bucketed Kruskal sequencer and union-find walk.
// Loading: one word per cycle while in_ready is high (load state only); a pair that passes the
// range and capacity check is written into the edge RAM in the cycle it is taken. After the
// last pair the parent table is reset, then each of the 127 weight buckets is visited in
// turn; in a used bucket every stored edge is read and, on a weight match, both finds walk
// the parent table. Then the output register loads, held off while an earlier result waits.
// Reset (rst, synchronous): node_count = 64, counters and sums cleared; edge RAM not cleared.
module road_rebuild_mst_cost
  import rbm_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [NODE_W-1:0] node_a,
  input  logic [NODE_W-1:0] node_b,
  input  logic              road_exists,
  input  logic [COST_W-1:0] build_cost,
  input  logic [COST_W-1:0] destroy_cost,
  input  logic              last_pair,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [TOT_W-1:0]  total_cost
);

  state_t            state;
  logic [CNT_W-1:0]  node_count;
  logic [EDGE_AW-1:0] edge_total;
  logic [EDGE_AW-1:0] eidx;
  logic [TOT_W-1:0]  destroy_total;
  logic [TOT_W-1:0]  tree_sum;
  logic [NUM_W-1:0]  present;
  logic [WIDX_W-1:0] widx;
  logic [NODE_W-1:0] cur;
  logic [NODE_W-1:0] ra;
  logic [NODE_W-1:0] node_b_hold;
  logic [NODE_W-1:0] init_cnt;

  logic [CNT_W-1:0]  limit;
  logic              take;
  logic              pair_ok;
  edge_t             wr_edge;
  edge_t             rd_edge;
  logic [NODE_W-1:0] par_q;
  logic              par_we;
  logic [NODE_W-1:0] par_waddr;
  logic [NODE_W-1:0] par_wdata;
  logic              last_edge;
  logic              last_w;

  assign pready   = 1'b1;
  assign prdata   = {{(32-CNT_W){1'b0}}, node_count};
  assign in_ready = (state == S_LOAD);
  assign take     = in_valid && in_ready;

  assign limit   = (node_count > CNT_W'(MAX_NODES)) ? CNT_W'(MAX_NODES) : node_count;
  assign pair_ok = ({1'b0, node_a} < limit) && ({1'b0, node_b} < limit)
                   && (edge_total < EDGE_AW'(MAX_EDGES));

  assign wr_edge.a  = node_a;
  assign wr_edge.b  = node_b;
  assign wr_edge.wb = road_exists ? WIDX_W'(WBIAS - int'(destroy_cost))
                                  : WIDX_W'(WBIAS + int'(build_cost));

  assign last_edge = (eidx + EDGE_AW'(1)) == edge_total;
  assign last_w    = widx == WIDX_W'(NUM_W - 1);

  rbm_edge_mem u_edges (
    .clk   (clk),
    .we    (take && pair_ok),
    .waddr (edge_total),
    .wdata (wr_edge),
    .raddr (eidx),
    .rdata (rd_edge)
  );

  always_comb begin
    par_we    = 1'b0;
    par_waddr = init_cnt;
    par_wdata = init_cnt;
    if (state == S_INIT) begin
      par_we = 1'b1;
    end else if (state == S_FB_CHK && par_q == cur && ra != cur) begin
      par_we    = 1'b1;
      par_waddr = ra;
      par_wdata = cur;
    end
  end

  rbm_parent_mem u_parent (
    .clk   (clk),
    .we    (par_we),
    .waddr (par_waddr),
    .wdata (par_wdata),
    .raddr (cur),
    .rdata (par_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_LOAD;
      node_count    <= CNT_W'(MAX_NODES);
      edge_total    <= '0;
      eidx          <= '0;
      destroy_total <= '0;
      tree_sum      <= '0;
      present       <= '0;
      widx          <= '0;
      init_cnt      <= '0;
      out_valid     <= 1'b0;
    end else begin
      if (psel && penable && pwrite && !paddr[2]) begin
        node_count <= pwdata[CNT_W-1:0];
      end
      // S_DONE handles the output register itself
      if (out_valid && out_ready && state != S_DONE) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_LOAD: begin
          if (take) begin
            if (pair_ok) begin
              edge_total       <= edge_total + EDGE_AW'(1);
              present[wr_edge.wb] <= 1'b1;
              if (road_exists) begin
                destroy_total <= destroy_total + TOT_W'(destroy_cost);
              end
            end
            if (last_pair) begin
              init_cnt <= '0;
              state    <= S_INIT;
            end
          end
        end
        S_INIT: begin
          init_cnt <= init_cnt + NODE_W'(1);
          if (init_cnt == NODE_W'(MAX_NODES - 1)) begin
            widx     <= '0;
            tree_sum <= '0;
            state    <= S_WSEL;
          end
        end
        S_WSEL: begin
          if (present[widx]) begin
            eidx  <= '0;
            state <= S_ERD;
          end else if (last_w) begin
            state <= S_DONE;
          end else begin
            widx <= widx + WIDX_W'(1);
          end
        end
        S_ERD: state <= S_ECHK;
        S_ECHK: begin
          if (rd_edge.wb == widx) begin
            cur         <= rd_edge.a;
            node_b_hold <= rd_edge.b;
            state       <= S_FA_RD;
          end else if (!last_edge) begin
            eidx  <= eidx + EDGE_AW'(1);
            state <= S_ERD;
          end else if (last_w) begin
            state <= S_DONE;
          end else begin
            widx  <= widx + WIDX_W'(1);
            state <= S_WSEL;
          end
        end
        S_FA_RD: state <= S_FA_CHK;
        S_FA_CHK: begin
          if (par_q == cur) begin
            ra    <= cur;
            cur   <= node_b_hold;
            state <= S_FB_RD;
          end else begin
            cur   <= par_q;
            state <= S_FA_RD;
          end
        end
        S_FB_RD: state <= S_FB_CHK;
        S_FB_CHK: begin
          if (par_q != cur) begin
            cur   <= par_q;
            state <= S_FB_RD;
          end else begin
            if (ra != cur) begin
              tree_sum <= tree_sum + TOT_W'(widx) - TOT_W'(WBIAS);
            end
            if (!last_edge) begin
              eidx  <= eidx + EDGE_AW'(1);
              state <= S_ERD;
            end else if (last_w) begin
              state <= S_DONE;
            end else begin
              widx  <= widx + WIDX_W'(1);
              state <= S_WSEL;
            end
          end
        end
        S_DONE: begin
          if (!out_valid || out_ready) begin
            out_valid     <= 1'b1;
            total_cost    <= tree_sum + destroy_total;
            edge_total    <= '0;
            destroy_total <= '0;
            tree_sum      <= '0;
            present       <= '0;
            state         <= S_LOAD;
          end
        end
        default: state <= S_LOAD;
      endcase
    end
  end

endmodule
